>>> hw/rtl/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants for the pressure sensor compensation core.
// ----------------------------------------------------------------------------
package psc_pkg;

  // field widths
  localparam int unsigned RawW  = 24;
  localparam int unsigned CoefW = 16;
  localparam int unsigned MbarW = 22;
  localparam int unsigned CfgIdxW = 3;

  // divide by ten: multiply by ceil(2^RecipShift / 10), exact below 2^27
  localparam int unsigned RecipShift = 30;
  localparam int unsigned RecipW     = 27;
  localparam logic [RecipW-1:0] RecipMult = 27'd107374183;

  // calibration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_COEF_SENS          = 3'd0,
    CFG_COEF_OFFSET        = 3'd1,
    CFG_COEF_SENS_TEMPCO   = 3'd2,
    CFG_COEF_OFFSET_TEMPCO = 3'd3,
    CFG_COEF_REF_TEMP      = 3'd4
  } cfg_idx_e;

  // input beat: raw conversions
  typedef struct packed {
    logic [RawW-1:0] raw_pressure;
    logic [RawW-1:0] raw_temperature;
  } in_beat_t;

  // output beat: compensated pressure
  typedef struct packed {
    logic signed [MbarW-1:0] pressure_mbar;
  } out_beat_t;

endpackage

>>> hw/rtl/psc_stream_if.sv
// ----------------------------------------------------------------------------
// psc_stream_if
// Valid/ready stream channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface psc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/pressure_sensor_compensation_core.sv
// ----------------------------------------------------------------------------
// pressure_sensor_compensation_core
// First-order compensation of raw pressure/temperature conversions using
// five calibration words, result in millibar.
// Throughput: one beat per cycle; ten register stages share one enable that
// drops only while the output register holds a beat that is not taken.
// Reset: rst_ni clears all stage valid bits and the calibration words to 0.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [psc_pkg::CoefW-1:0]     cfg_data_i,
  psc_stream_if.sink                    in_i,
  psc_stream_if.source                  out_o
);

  localparam int unsigned NumStages = 10;

  // calibration words
  logic [psc_pkg::CoefW-1:0] coef_sens_q, coef_offset_q, coef_sens_tempco_q;
  logic [psc_pkg::CoefW-1:0] coef_offset_tempco_q, coef_ref_temp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_sens_q          <= '0;
      coef_offset_q        <= '0;
      coef_sens_tempco_q   <= '0;
      coef_offset_tempco_q <= '0;
      coef_ref_temp_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        psc_pkg::CFG_COEF_SENS:          coef_sens_q          <= cfg_data_i;
        psc_pkg::CFG_COEF_OFFSET:        coef_offset_q        <= cfg_data_i;
        psc_pkg::CFG_COEF_SENS_TEMPCO:   coef_sens_tempco_q   <= cfg_data_i;
        psc_pkg::CFG_COEF_OFFSET_TEMPCO: coef_offset_tempco_q <= cfg_data_i;
        psc_pkg::CFG_COEF_REF_TEMP:      coef_ref_temp_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control: all stages advance together
  logic [NumStages-1:0] vld_q;
  logic                 en;

  assign en         = !vld_q[NumStages-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStages-2:0], in_i.valid};
    end
  end

  // stage 1: temperature delta
  logic        [23:0] s1_d1_q;
  logic signed [24:0] s1_dt_q, s1_dt_d;

  assign s1_dt_d = $signed({1'b0, in_i.payload.raw_temperature})
                 - $signed({1'b0, coef_ref_temp_q, 8'h00});

  // stage 2: temperature coefficient products
  logic        [23:0] s2_d1_q;
  logic signed [41:0] s2_off_prod_q, s2_off_prod_d;
  logic signed [41:0] s2_sens_prod_q, s2_sens_prod_d;

  assign s2_off_prod_d  = 42'($signed({1'b0, coef_offset_tempco_q})) * 42'(s1_dt_q);
  assign s2_sens_prod_d = 42'($signed({1'b0, coef_sens_tempco_q})) * 42'(s1_dt_q);

  // stage 3: offset and sensitivity, divisions truncate toward zero
  logic        [23:0] s3_d1_q;
  logic signed [35:0] s3_off_q, s3_off_d, s3_sens_q, s3_sens_d;
  logic signed [41:0] off_adj, off_shr, sens_adj, sens_shr;

  always_comb begin
    off_adj   = s2_off_prod_q + (s2_off_prod_q[41] ? 42'sd127 : 42'sd0);
    off_shr   = off_adj >>> 7;
    sens_adj  = s2_sens_prod_q + (s2_sens_prod_q[41] ? 42'sd255 : 42'sd0);
    sens_shr  = sens_adj >>> 8;
    s3_off_d  = $signed(off_shr[35:0] + {4'b0, coef_offset_q, 16'h0000});
    s3_sens_d = $signed(sens_shr[35:0] + {5'b0, coef_sens_q, 15'h0000});
  end

  // stage 4: raw pressure times sensitivity
  logic signed [60:0] s4_prod_q, s4_prod_d;
  logic signed [35:0] s4_off_q;

  assign s4_prod_d = 61'($signed({1'b0, s3_d1_q})) * 61'(s3_sens_q);

  // stage 5: divide by 2^21 toward zero
  logic signed [60:0] prod_adj, prod_shr;
  logic signed [39:0] s5_a_q, s5_a_d;
  logic signed [35:0] s5_off_q;

  always_comb begin
    prod_adj = s4_prod_q + (s4_prod_q[60] ? 61'sd2097151 : 61'sd0);
    prod_shr = prod_adj >>> 21;
    s5_a_d   = prod_shr[39:0];
  end

  // stage 6: subtract offset
  logic signed [40:0] s6_diff_q, s6_diff_d;

  assign s6_diff_d = {s5_a_q[39], s5_a_q} - {{5{s5_off_q[35]}}, s5_off_q};

  // stage 7: divide by 2^13 toward zero
  logic signed [40:0] diff_adj, diff_shr;
  logic signed [27:0] s7_p_q, s7_p_d;

  always_comb begin
    diff_adj = s6_diff_q + (s6_diff_q[40] ? 41'sd8191 : 41'sd0);
    diff_shr = diff_adj >>> 13;
    s7_p_d   = diff_shr[27:0];
  end

  // stage 8: magnitude and sign
  logic [27:0] s8_mag_q, s8_mag_d;
  logic        s8_neg_q;

  assign s8_mag_d = s7_p_q[27] ? 28'(-s7_p_q) : 28'(s7_p_q);

  // stage 9: reciprocal multiply for divide by ten
  logic [54:0] s9_prod_q, s9_prod_d;
  logic        s9_neg_q;

  assign s9_prod_d = {27'b0, s8_mag_q} * {28'b0, psc_pkg::RecipMult};

  // stage 10: quotient, restore sign into output register
  logic [24:0]                 quot;
  logic [psc_pkg::MbarW-1:0]   out_d, out_q;

  always_comb begin
    quot  = s9_prod_q[54:psc_pkg::RecipShift];
    out_d = s9_neg_q ? psc_pkg::MbarW'(-quot) : quot[psc_pkg::MbarW-1:0];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_d1_q        <= in_i.payload.raw_pressure;
      s1_dt_q        <= s1_dt_d;
      s2_d1_q        <= s1_d1_q;
      s2_off_prod_q  <= s2_off_prod_d;
      s2_sens_prod_q <= s2_sens_prod_d;
      s3_d1_q        <= s2_d1_q;
      s3_off_q       <= s3_off_d;
      s3_sens_q      <= s3_sens_d;
      s4_prod_q      <= s4_prod_d;
      s4_off_q       <= s3_off_q;
      s5_a_q         <= s5_a_d;
      s5_off_q       <= s4_off_q;
      s6_diff_q      <= s6_diff_d;
      s7_p_q         <= s7_p_d;
      s8_mag_q       <= s8_mag_d;
      s8_neg_q       <= s7_p_q[27];
      s9_prod_q      <= s9_prod_d;
      s9_neg_q       <= s8_neg_q;
      out_q          <= out_d;
    end
  end

  assign out_o.valid                 = vld_q[NumStages-1];
  assign out_o.payload.pressure_mbar = $signed(out_q);

  // assertions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input taken while output beat is stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[8] |-> s9_prod_q[54:psc_pkg::RecipShift+psc_pkg::MbarW-1] == '0)
    else $error("quotient exceeds output range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[7] |-> !s8_mag_q[27])
    else $error("pressure magnitude outside divider range");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pressure_sensor_compensation_core: drives raw
// pressure/temperature beats under random source gaps and sink stalls, keeps
// its own 64-bit model of the first-order compensation and compares every
// output beat in order against it.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CfgCount    = 5;
  localparam int unsigned PipeLatency = 10;
  localparam int unsigned MaxReports  = 40;
  localparam int unsigned RandPhases  = 8;
  localparam int unsigned PhaseBeats  = 240;

  // compensation scale factors
  localparam longint RefTempScale  = 256;
  localparam longint OffsetScale   = 65536;
  localparam longint OffTcoDiv     = 128;
  localparam longint SensScale     = 32768;
  localparam longint SensTcoDiv    = 256;
  localparam longint SensProductDiv = 2097152;
  localparam longint PressureDiv   = 8192;
  localparam longint MbarDiv       = 10;

  localparam logic [psc_pkg::RawW-1:0] RawMax = '1;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [psc_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [psc_pkg::CoefW-1:0]   cfg_data_i;

  psc_stream_if #(.payload_t(psc_pkg::in_beat_t))  sample_if ();
  psc_stream_if #(.payload_t(psc_pkg::out_beat_t)) mbar_if ();

  pressure_sensor_compensation_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (sample_if),
    .out_o      (mbar_if)
  );

  // calibration words as the core should hold them
  logic [psc_pkg::CoefW-1:0] cal_word [CfgCount];

  logic signed [psc_pkg::MbarW-1:0] mbar_expected [$];
  int unsigned err_count;
  bit          tx_idle;
  bit          rx_idle;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MaxReports) $display("mismatch: %s", msg);
  endtask

  // first-order compensation, signed 64-bit, divisions truncate toward zero
  function automatic logic signed [psc_pkg::MbarW-1:0] compensate_mbar(
    input logic [psc_pkg::RawW-1:0] d1,
    input logic [psc_pkg::RawW-1:0] d2
  );
    longint dt, off, sens, p;
    dt   = longint'(d2)
         - longint'(cal_word[psc_pkg::CFG_COEF_REF_TEMP]) * RefTempScale;
    off  = longint'(cal_word[psc_pkg::CFG_COEF_OFFSET]) * OffsetScale
         + (longint'(cal_word[psc_pkg::CFG_COEF_OFFSET_TEMPCO]) * dt) / OffTcoDiv;
    sens = longint'(cal_word[psc_pkg::CFG_COEF_SENS]) * SensScale
         + (longint'(cal_word[psc_pkg::CFG_COEF_SENS_TEMPCO]) * dt) / SensTcoDiv;
    p    = ((longint'(d1) * sens) / SensProductDiv - off) / PressureDiv;
    p    = p / MbarDiv;
    return p[psc_pkg::MbarW-1:0];
  endfunction

  // predict on accepted input beats, check accepted output beats
  always @(posedge clk_i) begin : check_results
    logic signed [psc_pkg::MbarW-1:0] want;
    if (rst_ni) begin
      if (sample_if.valid && sample_if.ready)
        mbar_expected.push_back(compensate_mbar(sample_if.payload.raw_pressure,
                                                sample_if.payload.raw_temperature));
      if (mbar_if.valid && mbar_if.ready) begin
        if (mbar_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, pressure_mbar=%0d",
                                    mbar_if.payload.pressure_mbar));
        end else begin
          want = mbar_expected.pop_front();
          if (mbar_if.payload.pressure_mbar !== want)
            report_mismatch($sformatf("pressure_mbar got %0d want %0d",
                                      mbar_if.payload.pressure_mbar, want));
        end
      end
    end
  end

  // sink side: random stall before each beat when enabled
  initial begin : drain_output
    int gap;
    mbar_if.ready <= 1'b0;
    forever begin
      gap = rx_idle ? $urandom_range(3, 0) : 0;
      if (gap > 0) begin
        mbar_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      mbar_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!mbar_if.valid) @(posedge clk_i);
    end
  end

  // one input beat, held until taken
  task automatic send_sample(input logic [psc_pkg::RawW-1:0] d1,
                             input logic [psc_pkg::RawW-1:0] d2);
    int gap;
    psc_pkg::in_beat_t beat;
    gap = tx_idle ? $urandom_range(3, 0) : 0;
    beat.raw_pressure    = d1;
    beat.raw_temperature = d2;
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_if.valid   <= 1'b1;
    sample_if.payload <= beat;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
  endtask

  task automatic stop_input();
    sample_if.valid <= 1'b0;
  endtask

  // wait until every expected beat is out and the pipe has settled
  task automatic wait_idle();
    @(posedge clk_i);
    while (mbar_expected.size() != 0) @(posedge clk_i);
    repeat (PipeLatency) @(posedge clk_i);
  endtask

  task automatic write_coef(input logic [psc_pkg::CfgIdxW-1:0] idx,
                            input logic [psc_pkg::CoefW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    if (idx < CfgCount) cal_word[idx] = value;
  endtask

  task automatic program_coefs(input logic [psc_pkg::CoefW-1:0] c1,
                               input logic [psc_pkg::CoefW-1:0] c2,
                               input logic [psc_pkg::CoefW-1:0] c3,
                               input logic [psc_pkg::CoefW-1:0] c4,
                               input logic [psc_pkg::CoefW-1:0] c5);
    write_coef(psc_pkg::CFG_COEF_SENS, c1);
    write_coef(psc_pkg::CFG_COEF_OFFSET, c2);
    write_coef(psc_pkg::CFG_COEF_SENS_TEMPCO, c3);
    write_coef(psc_pkg::CFG_COEF_OFFSET_TEMPCO, c4);
    write_coef(psc_pkg::CFG_COEF_REF_TEMP, c5);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [psc_pkg::CoefW-1:0] pick_coef();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return '1;
      default: return psc_pkg::CoefW'($urandom);
    endcase
  endfunction

  function automatic logic [psc_pkg::RawW-1:0] pick_raw_pressure();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return RawMax;
      default: return psc_pkg::RawW'($urandom);
    endcase
  endfunction

  // temperature beats cluster around the reference so dT crosses zero often
  function automatic logic [psc_pkg::RawW-1:0] pick_raw_temperature();
    longint t;
    case ($urandom_range(7, 0))
      0: return '0;
      1: return RawMax;
      2, 3: begin
        t = longint'(cal_word[psc_pkg::CFG_COEF_REF_TEMP]) * RefTempScale
          + longint'($urandom_range(600, 0)) - 300;
        if (t < 0) t = 0;
        if (t > longint'(RawMax)) t = longint'(RawMax);
        return t[psc_pkg::RawW-1:0];
      end
      default: return psc_pkg::RawW'($urandom);
    endcase
  endfunction

  // all words still zero after reset: output must be zero
  task automatic test_reset_defaults();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_sample('0, '0);
    send_sample(RawMax, RawMax);
    send_sample(RawMax, '0);
    stop_input();
    wait_idle();
  endtask

  // typical calibration, input fields at their extremes and patterns
  task automatic test_field_extremes();
    logic [psc_pkg::RawW-1:0] ref_raw;
    program_coefs(16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646);
    ref_raw = psc_pkg::RawW'(longint'(cal_word[psc_pkg::CFG_COEF_REF_TEMP])
                             * RefTempScale);
    send_sample('0, '0);
    send_sample(RawMax, RawMax);
    send_sample(RawMax, '0);
    send_sample('0, RawMax);
    send_sample(24'h800000, ref_raw);
    send_sample(24'hAAAAAA, 24'h555555);
    send_sample(24'h555555, 24'hAAAAAA);
    send_sample(RawMax, ref_raw - 1'b1);
    send_sample(24'd1, ref_raw + 1'b1);
    stop_input();
    wait_idle();
  endtask

  // calibration words at their extremes, pushing the result both ways
  task automatic test_coef_extremes();
    program_coefs('1, '1, '1, '1, '1);
    send_sample(RawMax, RawMax);
    send_sample(RawMax, '0);
    send_sample('0, '0);
    stop_input();
    wait_idle();
    program_coefs('1, '0, '1, '1, '0);
    send_sample(RawMax, RawMax);
    stop_input();
    wait_idle();
    program_coefs('0, '1, '0, '1, '1);
    send_sample(RawMax, '0);
    send_sample('0, '0);
    stop_input();
    wait_idle();
  endtask

  // writes to indexes past the last register must be dropped
  task automatic test_unused_index();
    program_coefs(16'd40000, 16'd30000, 16'd25000, 16'd20000, 16'd30000);
    for (int i = CfgCount; i < (1 << psc_pkg::CfgIdxW); i++)
      write_coef(psc_pkg::CfgIdxW'(i), '1);
    cfg_we_i <= 1'b0;
    send_sample(24'h9A0000, 24'h7A0000);
    send_sample(RawMax, RawMax);
    stop_input();
    wait_idle();
  endtask

  // calibration per phase (all-ones and alternating first, then random), random beats, rotating idle patterns
  task automatic test_random_traffic();
    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0: program_coefs('1, '1, '1, '1, '1);
        1: program_coefs('1, '0, '1, '0, '1);
        default: program_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                               pick_coef());
      endcase
      tx_idle = (ph % 4) != 1 && (ph % 4) != 3;
      rx_idle = (ph % 4) < 2;
      for (int n = 0; n < PhaseBeats; n++)
        send_sample(pick_raw_pressure(), pick_raw_temperature());
      stop_input();
      wait_idle();
    end
  endtask

  // main sequence
  initial begin
    err_count = 0;
    tx_idle   = 1'b0;
    rx_idle   = 1'b0;
    foreach (cal_word[i]) cal_word[i] = '0;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= '0;
    cfg_data_i        <= '0;
    sample_if.valid   <= 1'b0;
    sample_if.payload <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_field_extremes();
    test_coef_extremes();
    test_unused_index();
    test_random_traffic();

    wait_idle();
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
